[hdl/stable_sorted_priority_queue_unit_macros.svh]
// Assertion macros shared by the checker of the sorted priority queue unit.
// Depends on nothing; the including file supplies clock, reset and signals.
`ifndef STABLE_SORTED_PRIORITY_QUEUE_UNIT_MACROS_SVH
`define STABLE_SORTED_PRIORITY_QUEUE_UNIT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define SSQ_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("sorted queue check failed");

// Next-cycle implication, checked outside reset.
`define SSQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("sorted queue check failed");

`endif

[hdl/ssq_pkg.sv]
// Shared types and constants of the stable sorted priority queue unit.
// Used by the controller, the datapath, the top level and the checker.
package ssq_pkg;

	localparam int DEPTH      = 16;
	localparam int PRIO_WIDTH = 16;
	localparam int DATA_WIDTH = 32;
	localparam int CNT_W      = $clog2(DEPTH + 1);

	// Lowest representable priority; a cut-in saturates here.
	localparam logic signed [PRIO_WIDTH-1:0] PRIO_MIN = {1'b1, {(PRIO_WIDTH-1){1'b0}}};

	typedef enum logic [1:0] {
		CMD_INSERT = 2'd0,
		CMD_REMOVE = 2'd1,
		CMD_CUT_IN = 2'd2,
		CMD_QUERY  = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	typedef struct packed {
		cmd_t                          cmd;
		logic signed [PRIO_WIDTH-1:0]  prio;
		logic signed [DATA_WIDTH-1:0]  payload;
	} ssq_in_t;

	typedef struct packed {
		logic signed [DATA_WIDTH-1:0]  removed_data;
		logic signed [DATA_WIDTH-1:0]  tail_data;
		logic signed [DATA_WIDTH-1:0]  middle_data;
		logic [CNT_W-1:0]              entry_count;
		logic                          is_empty;
		status_t                       status;
	} ssq_out_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic update;
		logic report;
	} ssq_ctl_t;

endpackage

[hdl/ssq_ctrl.sv]
// Controller of the sorted priority queue: sequences the update and report cycles.
// Depends on ssq_pkg.
module ssq_ctrl import ssq_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	output logic     busy,
	output ssq_ctl_t ctl,
	output logic     done
);

	typedef enum logic {
		S_IDLE,
		S_REPORT
	} state_t;

	state_t state_q;
	logic   done_q;

	// A beat is taken only in the idle state; the report cycle follows it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done_q  <= 1'b0;
		end else begin
			done_q <= (state_q == S_REPORT);
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						state_q <= S_REPORT;
					end
				end
				S_REPORT: begin
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Commands and status toward the datapath and the ports.
	always_comb begin
		busy       = (state_q == S_REPORT);
		ctl.update = start && (state_q == S_IDLE);
		ctl.report = (state_q == S_REPORT);
		done       = done_q;
	end

endmodule

[hdl/ssq_datapath.sv]
// Datapath of the sorted priority queue: a row of compare-and-shift cells,
// the fill count and the result register. Depends on ssq_pkg.
module ssq_datapath import ssq_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  ssq_ctl_t ctl,
	input  ssq_in_t  item,
	output ssq_out_t result
);

	logic signed [PRIO_WIDTH-1:0] prio_q [DEPTH];
	logic signed [DATA_WIDTH-1:0] data_q [DEPTH];
	logic signed [PRIO_WIDTH-1:0] prio_d [DEPTH];
	logic signed [DATA_WIDTH-1:0] data_d [DEPTH];
	logic [CNT_W-1:0]             cnt_q;
	logic [CNT_W-1:0]             cnt_d;
	status_t                      status_q;
	status_t                      status_d;
	logic signed [DATA_WIDTH-1:0] removed_q;
	logic signed [DATA_WIDTH-1:0] removed_d;
	logic [DEPTH-1:0]             ahead;
	logic                         empty;
	logic                         full;
	logic                         do_ins;
	logic                         do_rem;
	logic                         do_cut;
	logic signed [PRIO_WIDTH-1:0] cut_prio;
	logic signed [DATA_WIDTH-1:0] tail_sel;
	logic signed [DATA_WIDTH-1:0] mid_sel;
	ssq_out_t                     result_q;

	// Each cell compares its own priority with the incoming one.
	always_comb begin
		for (int i = 0; i < DEPTH; i++) begin
			ahead[i] = (CNT_W'(i) < cnt_q) && (prio_q[i] <= item.prio);
		end
	end

	// Operation decode and the outcome status.
	always_comb begin
		empty    = (cnt_q == '0);
		full     = (cnt_q == CNT_W'(DEPTH));
		do_ins   = (item.cmd == CMD_INSERT) && !full;
		do_rem   = (item.cmd == CMD_REMOVE) && !empty;
		do_cut   = (item.cmd == CMD_CUT_IN) && !empty && !full;
		cut_prio = (prio_q[0] == PRIO_MIN) ? prio_q[0] : prio_q[0] - PRIO_WIDTH'(1);
		status_d = ST_OK;
		case (item.cmd)
			CMD_INSERT: status_d = full ? ST_FULL : ST_OK;
			CMD_REMOVE: status_d = empty ? ST_EMPTY : ST_OK;
			CMD_CUT_IN: begin
				if (empty) begin
					status_d = ST_EMPTY;
				end else if (full) begin
					status_d = ST_FULL;
				end
			end
			default: status_d = ST_OK;
		endcase
		cnt_d = cnt_q;
		if (do_ins || do_cut) begin
			cnt_d = cnt_q + CNT_W'(1);
		end else if (do_rem) begin
			cnt_d = cnt_q - CNT_W'(1);
		end
		removed_d = do_rem ? data_q[0] : '0;
	end

	// Next cell contents: keep, take the new entry, or shift by one place.
	always_comb begin
		for (int i = 0; i < DEPTH; i++) begin
			prio_d[i] = prio_q[i];
			data_d[i] = data_q[i];
		end
		if (do_ins) begin
			if (!ahead[0]) begin
				prio_d[0] = item.prio;
				data_d[0] = item.payload;
			end
			for (int i = 1; i < DEPTH; i++) begin
				if (!ahead[i]) begin
					if (ahead[i-1]) begin
						prio_d[i] = item.prio;
						data_d[i] = item.payload;
					end else begin
						prio_d[i] = prio_q[i-1];
						data_d[i] = data_q[i-1];
					end
				end
			end
		end else if (do_cut) begin
			prio_d[0] = cut_prio;
			data_d[0] = item.payload;
			for (int i = 1; i < DEPTH; i++) begin
				prio_d[i] = prio_q[i-1];
				data_d[i] = data_q[i-1];
			end
		end else if (do_rem) begin
			for (int i = 0; i < DEPTH - 1; i++) begin
				prio_d[i] = prio_q[i+1];
				data_d[i] = data_q[i+1];
			end
		end
	end

	// Cell storage holds only priorities and payloads and needs no reset.
	always_ff @(posedge clk) begin
		if (ctl.update) begin
			for (int i = 0; i < DEPTH; i++) begin
				prio_q[i] <= prio_d[i];
				data_q[i] <= data_d[i];
			end
		end
	end

	// Fill count and per-beat outcome.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q     <= '0;
			status_q  <= ST_OK;
			removed_q <= '0;
		end else if (ctl.update) begin
			cnt_q     <= cnt_d;
			status_q  <= status_d;
			removed_q <= removed_d;
		end
	end

	// Tail and middle pick: each cell matches its own index against the count.
	always_comb begin
		tail_sel = '0;
		mid_sel  = '0;
		for (int i = 0; i < DEPTH; i++) begin
			if (cnt_q == CNT_W'(i + 1)) begin
				tail_sel = tail_sel | data_q[i];
			end
			if (!empty && ((cnt_q >> 1) == CNT_W'(i))) begin
				mid_sel = mid_sel | data_q[i];
			end
		end
	end

	// Result register, loaded in the report cycle.
	always_ff @(posedge clk) begin
		if (ctl.report) begin
			result_q.removed_data <= removed_q;
			result_q.tail_data    <= tail_sel;
			result_q.middle_data  <= mid_sel;
			result_q.entry_count  <= cnt_q;
			result_q.is_empty     <= empty;
			result_q.status       <= status_q;
		end
	end

	assign result = result_q;

endmodule

[hdl/stable_sorted_priority_queue_unit.sv]
// Stable sorted priority queue of DEPTH entries with a start/busy command port.
// An accepted beat (start high, busy low) updates the queue at that edge; busy
// is then high for one cycle, and the result appears with done high for exactly
// one cycle right after that, when busy is low and a new beat can be taken. The
// steps are the cell update and the registered tail/middle selection.
// The receiver cannot stall: a result not taken in its done cycle is gone.
// Depends on ssq_pkg, ssq_ctrl and ssq_datapath.
module stable_sorted_priority_queue_unit import ssq_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	input  ssq_in_t  item,
	output logic     busy,
	output logic     done,
	output ssq_out_t result
);

	ssq_ctl_t ctl;

	// Sequencing of update and report cycles.
	ssq_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.ctl    (ctl),
		.done   (done)
	);

	// Cells, count and result register.
	ssq_datapath u_datapath (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.item   (item),
		.result (result)
	);

endmodule

[hdl/ssq_checker.sv]
// Port-level checker for the stable sorted priority queue unit, with its bind.
// Depends on ssq_pkg and stable_sorted_priority_queue_unit_macros.svh.
`include "stable_sorted_priority_queue_unit_macros.svh"

module ssq_checker import ssq_pkg::*; (
	input logic     clk,
	input logic     arst_n,
	input logic     start,
	input ssq_in_t  item,
	input logic     busy,
	input logic     done,
	input ssq_out_t result
);

	logic accept;

	assign accept = start && !busy;

	// Every accepted beat blocks the port for the next cycle.
	`SSQ_ASSERT_NEXT(a_accept_busy, clk, arst_n, accept, busy)

	// Every accepted beat yields a result with done high after its report cycle.
	`SSQ_ASSERT_NOW(a_result_follows, clk, arst_n, $past(accept, 2), done)

	// The empty flag agrees with the count, which never exceeds the depth.
	`SSQ_ASSERT_NOW(a_empty_count, clk, arst_n, done, (result.is_empty == (result.entry_count == '0)) && (result.entry_count <= CNT_W'(DEPTH)))

	// An empty queue reports no tail or middle data.
	`SSQ_ASSERT_NOW(a_empty_data, clk, arst_n, done && result.is_empty, (result.tail_data == '0) && (result.middle_data == '0))

endmodule

bind stable_sorted_priority_queue_unit ssq_checker u_ssq_checker (.*);
